/* rtl/assert_macros.svh */
// assertion macros shared by the receiver rtl
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SRR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/srr_pkg.sv */
// types and constants of the selective repeat receiver
// no dependencies
`default_nettype none

package srr_pkg;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 11;
    localparam int HDL_W  = 8;
    localparam int FILE_W = 16;
    localparam int WIN_W  = 6;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd32;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_DISCARD = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_END   = 2'd1,
        OP_DATA  = 2'd2,
        OP_BAD   = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEQ_W-1:0] seq_num;
        logic [LEN_W-1:0] payload_length;
        logic [31:0]      header_checksum;
        logic [31:0]      payload_crc;
        logic [HDL_W-1:0] payload_handle;
    } t_in_word;

    typedef struct packed {
        t_kind             kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [HDL_W-1:0]  out_handle;
        logic [LEN_W-1:0]  out_length;
        logic [FILE_W-1:0] file_number;
        logic              last;
    } t_out_word;

    typedef struct packed {
        t_op              op;
        logic [SEQ_W-1:0] seq_num;
        logic [LEN_W-1:0] payload_length;
        logic [HDL_W-1:0] payload_handle;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/srr_ram.sv */
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module srr_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]               i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                    o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

/* rtl/srr_fifo.sv */
// small synchronous queue of flip-flops
// includes assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module srr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_go;
    logic             rd_go;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_go   = i_push && !o_full;
    assign rd_go   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_go) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + 1'b1;
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SRR_ASSERT(a_fifo_count_bound, (r_count <= CNT_FULL), "queue count above depth")

endmodule

`default_nettype wire

/* rtl/srr_front.sv */
// front part: takes packet headers, checks length and checksum, drops ignored types
// uses srr_pkg
`default_nettype none

module srr_front #(
    parameter int MAX_PAYLOAD = 1456
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire srr_pkg::t_in_word i_item,
    output logic                  o_full,
    output logic                  o_cmd_push,
    output srr_pkg::t_cmd         o_cmd,
    input  wire logic             i_cmd_full
);

    localparam logic [srr_pkg::LEN_W-1:0] LEN_MAX = srr_pkg::LEN_W'(MAX_PAYLOAD);

    logic          r_valid;
    srr_pkg::t_cmd r_cmd;
    logic          n_valid;
    srr_pkg::t_cmd n_cmd;
    logic          accept;
    logic          drain;
    logic          keep;
    logic          bad;

    assign o_full     = r_valid && i_cmd_full;
    assign o_cmd_push = r_valid;
    assign o_cmd      = r_cmd;
    assign accept     = i_push && !o_full;
    assign drain      = r_valid && !i_cmd_full;

    always_comb begin
        bad = (i_item.payload_length == '0) || (i_item.payload_length > LEN_MAX)
              || (i_item.header_checksum != i_item.payload_crc);
        n_cmd.seq_num        = i_item.seq_num;
        n_cmd.payload_length = i_item.payload_length;
        n_cmd.payload_handle = i_item.payload_handle;
        keep                 = 1'b1;
        case (i_item.action)
            srr_pkg::ACT_START: n_cmd.op = srr_pkg::OP_START;
            srr_pkg::ACT_END:   n_cmd.op = srr_pkg::OP_END;
            srr_pkg::ACT_DATA:  n_cmd.op = bad ? srr_pkg::OP_BAD : srr_pkg::OP_DATA;
            default: begin
                n_cmd.op = srr_pkg::OP_START;
                keep     = 1'b0;
            end
        endcase
        if (accept) begin
            n_valid = keep;
        end else if (drain) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/srr_back.sv */
// back part: connection state, window store and result sequencing
// uses srr_pkg, srr_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module srr_back #(
    parameter int WINDOW_MAX  = 32,
    parameter int HANDLE_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [srr_pkg::WIN_W-1:0] i_cfg_wr_data,
    input  wire srr_pkg::t_cmd             i_cmd,
    input  wire logic                      i_cmd_empty,
    output logic                           o_cmd_pop,
    output logic                           o_res_push,
    output srr_pkg::t_out_word             o_res,
    input  wire logic                      i_res_full
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = HANDLE_BITS + srr_pkg::LEN_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_MAX - 1);
    localparam logic [IDX_W:0]   WMAX_EXT = (IDX_W + 1)'(WINDOW_MAX);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(WINDOW_MAX);
    localparam logic [srr_pkg::WIN_W-1:0] WIN_CAP = srr_pkg::WIN_W'(WINDOW_MAX);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DUP,
        S_DLV,
        S_RD,
        S_OUT,
        S_OLD_RD,
        S_OLD_OUT,
        S_SCAN,
        S_SCAN_D
    } t_state;

    t_state              r_state,     n_state;
    logic                r_connected, n_connected;
    logic [31:0]         r_exp,       n_exp;
    logic [IDX_W-1:0]    r_exp_idx,   n_exp_idx;
    logic [31:0]         r_start_seq, n_start_seq;
    logic [15:0]         r_file,      n_file;
    logic [WINDOW_MAX-1:0] r_valid,   n_valid;
    logic [srr_pkg::WIN_W-1:0] r_win;
    srr_pkg::t_cmd       r_cmd,       n_cmd;
    logic                r_in_win,    n_in_win;
    logic                r_below,     n_below;
    logic                r_equal,     n_equal;
    logic [IDX_W-1:0]    r_idx,       n_idx;
    logic [CNT_W-1:0]    r_cnt,       n_cnt;
    logic [IDX_W-1:0]    r_sidx,      n_sidx;
    logic [31:0]         r_sseq,      n_sseq;
    logic [31:0]         r_dseq,      n_dseq;
    srr_pkg::t_out_word  r_hold,      n_hold;

    logic [31:0]         diff;
    logic [IDX_W:0]      slot_sum;
    logic [srr_pkg::WIN_W-1:0] win;
    logic [32:0]         limit;
    logic [IDX_W-1:0]    nidx_exp;
    logic [IDX_W-1:0]    nidx_scan;
    logic                more;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [SLOT_W-1:0]   ram_wr_data;
    logic [SLOT_W-1:0]   ram_q;
    logic [7:0]          ram_handle;
    logic [srr_pkg::LEN_W-1:0] ram_len;
    logic [7:0]          cmd_handle;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [31:0] s);
        if (s == '1) begin
            return '0;
        end else if (idx == IDX_LAST) begin
            return '0;
        end else begin
            return idx + 1'b1;
        end
    endfunction

    function automatic srr_pkg::t_out_word mk_word(input srr_pkg::t_kind k,
                                                   input logic [31:0] s,
                                                   input logic [7:0] h,
                                                   input logic [srr_pkg::LEN_W-1:0] l,
                                                   input logic [15:0] f,
                                                   input logic lst);
        srr_pkg::t_out_word w;
        w.kind        = k;
        w.out_seq     = s;
        w.out_handle  = h;
        w.out_length  = l;
        w.file_number = f;
        w.last        = lst;
        return w;
    endfunction

    srr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WINDOW_MAX)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_q)
    );

    assign ram_handle  = 8'(ram_q[SLOT_W-1:srr_pkg::LEN_W]);
    assign ram_len     = ram_q[srr_pkg::LEN_W-1:0];
    assign cmd_handle  = 8'(HANDLE_BITS'(r_cmd.payload_handle));
    assign ram_wr_data = {HANDLE_BITS'(r_cmd.payload_handle), r_cmd.payload_length};
    assign nidx_exp    = next_idx(r_exp_idx, r_exp);
    assign nidx_scan   = next_idx(r_sidx, r_sseq);

    // window check and slot index for the word at the head of the queue
    always_comb begin
        diff     = i_cmd.seq_num - r_exp;
        slot_sum = {1'b0, r_exp_idx} + {1'b0, diff[IDX_W-1:0]};
        win      = (r_win < WIN_CAP) ? r_win : WIN_CAP;
        limit    = {1'b0, r_exp} + {{(33 - srr_pkg::WIN_W){1'b0}}, win};
    end

    always_comb begin
        n_state     = r_state;
        n_connected = r_connected;
        n_exp       = r_exp;
        n_exp_idx   = r_exp_idx;
        n_start_seq = r_start_seq;
        n_file      = r_file;
        n_valid     = r_valid;
        n_cmd       = r_cmd;
        n_in_win    = r_in_win;
        n_below     = r_below;
        n_equal     = r_equal;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_sidx      = r_sidx;
        n_sseq      = r_sseq;
        n_dseq      = r_dseq;
        n_hold      = r_hold;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = r_hold;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_exp_idx;
        more        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_in_win  = ({1'b0, i_cmd.seq_num} < limit);
                    n_below   = (i_cmd.seq_num < r_exp);
                    n_equal   = (i_cmd.seq_num == r_exp);
                    n_idx     = (slot_sum >= WMAX_EXT) ? IDX_W'(slot_sum - WMAX_EXT)
                                                       : slot_sum[IDX_W-1:0];
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    srr_pkg::OP_START: begin
                        if (r_connected) begin
                            n_state = S_IDLE;
                        end else if (!i_res_full) begin
                            o_res_push  = 1'b1;
                            o_res       = mk_word(srr_pkg::KIND_ACK, r_cmd.seq_num, 8'd0,
                                                  '0, r_file, 1'b1);
                            n_start_seq = r_cmd.seq_num;
                            n_exp       = '0;
                            n_exp_idx   = '0;
                            n_valid     = '0;
                            n_connected = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    srr_pkg::OP_END: begin
                        if (!r_connected) begin
                            n_state = S_IDLE;
                        end else begin
                            n_hold  = mk_word(srr_pkg::KIND_ACK, r_start_seq, 8'd0, '0,
                                              r_file, 1'b0);
                            n_cnt   = '0;
                            n_sidx  = r_exp_idx;
                            n_sseq  = r_exp;
                            n_state = S_SCAN;
                        end
                    end
                    srr_pkg::OP_DATA, srr_pkg::OP_BAD: begin
                        if (!r_connected) begin
                            n_state = S_IDLE;
                        end else if (!i_res_full) begin
                            o_res_push = 1'b1;
                            if (r_cmd.op == srr_pkg::OP_BAD || !r_in_win) begin
                                o_res   = mk_word(srr_pkg::KIND_DISCARD, r_cmd.seq_num,
                                                  cmd_handle, '0, r_file, 1'b1);
                                n_state = S_IDLE;
                            end else begin
                                o_res = mk_word(srr_pkg::KIND_ACK, r_cmd.seq_num, 8'd0, '0,
                                                r_file, !(r_below || r_equal || r_valid[r_idx]));
                                if (r_below) begin
                                    n_state = S_DUP;
                                end else if (r_equal) begin
                                    n_state = S_DLV;
                                end else if (r_valid[r_idx]) begin
                                    n_state = S_OLD_RD;
                                end else begin
                                    ram_wr_en      = 1'b1;
                                    n_valid[r_idx] = 1'b1;
                                    n_state        = S_IDLE;
                                end
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DUP: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = mk_word(srr_pkg::KIND_DISCARD, r_cmd.seq_num, cmd_handle,
                                         '0, r_file, 1'b1);
                    n_state    = S_IDLE;
                end
            end
            S_DLV: begin
                if (!i_res_full) begin
                    more       = r_valid[nidx_exp];
                    o_res_push = 1'b1;
                    o_res      = mk_word(srr_pkg::KIND_DELIVER, r_exp, cmd_handle,
                                         r_cmd.payload_length, r_file, !more);
                    n_exp      = r_exp + 32'd1;
                    n_exp_idx  = nidx_exp;
                    n_state    = more ? S_RD : S_IDLE;
                end
            end
            S_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_exp_idx;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_res_full) begin
                    more               = (nidx_exp != r_exp_idx) && r_valid[nidx_exp];
                    o_res_push         = 1'b1;
                    o_res              = mk_word(srr_pkg::KIND_DELIVER, r_exp, ram_handle,
                                                 ram_len, r_file, !more);
                    n_valid[r_exp_idx] = 1'b0;
                    n_exp              = r_exp + 32'd1;
                    n_exp_idx          = nidx_exp;
                    n_state            = more ? S_RD : S_IDLE;
                end
            end
            S_OLD_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_idx;
                n_state     = S_OLD_OUT;
            end
            S_OLD_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = mk_word(srr_pkg::KIND_DISCARD, r_cmd.seq_num, ram_handle,
                                         '0, r_file, 1'b1);
                    ram_wr_en  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_cnt == CNT_END) begin
                    if (!i_res_full) begin
                        o_res_push  = 1'b1;
                        o_res       = r_hold;
                        o_res.last  = 1'b1;
                        n_connected = 1'b0;
                        n_file      = r_file + 16'd1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_cnt  = r_cnt + 1'b1;
                    n_sseq = r_sseq + 32'd1;
                    n_sidx = nidx_scan;
                    if (r_valid[r_sidx]) begin
                        ram_rd_en       = 1'b1;
                        ram_rd_addr     = r_sidx;
                        n_valid[r_sidx] = 1'b0;
                        n_dseq          = r_sseq;
                        n_state         = S_SCAN_D;
                    end
                end
            end
            S_SCAN_D: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = r_hold;
                    n_hold     = mk_word(srr_pkg::KIND_DISCARD, r_dseq, ram_handle, '0,
                                         r_file, 1'b0);
                    n_state    = S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_in_win <= n_in_win;
        r_below  <= n_below;
        r_equal  <= n_equal;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_sidx   <= n_sidx;
        r_sseq   <= n_sseq;
        r_dseq   <= n_dseq;
        r_hold   <= n_hold;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_connected <= 1'b0;
            r_exp       <= '0;
            r_exp_idx   <= '0;
            r_start_seq <= '0;
            r_file      <= '0;
            r_valid     <= '0;
            r_win       <= srr_pkg::WINDOW_RESET;
        end else begin
            r_state     <= n_state;
            r_connected <= n_connected;
            r_exp       <= n_exp;
            r_exp_idx   <= n_exp_idx;
            r_start_seq <= n_start_seq;
            r_file      <= n_file;
            r_valid     <= n_valid;
            if (i_cfg_wr_en) begin
                r_win <= i_cfg_wr_data;
            end
        end
    end

    `SRR_ASSERT(a_end_closes, (r_state == S_SCAN && r_cnt == CNT_END && !i_res_full) |=> !r_connected, "connection still open after end scan")
    `SRR_ASSERT(a_deliver_advances, (o_res_push && o_res.kind == srr_pkg::KIND_DELIVER) |=> (r_exp == $past(r_exp) + 32'd1), "delivery without advance of expected sequence")
    `SRR_ASSERT(a_start_clears, (r_state == S_EXEC && r_cmd.op == srr_pkg::OP_START && !r_connected && !i_res_full) |=> (r_valid == '0 && r_exp == '0 && r_connected), "start did not reset the window")

endmodule

`default_nettype wire

/* rtl/selective_repeat_receiver.sv */
// selective repeat receiver: header front end, command queue, window back end, result queue
// items pass the front register and command queue; the back end ends each command before the next
// each buffered packet drained on delivery needs a registered slot store read
// end of connection scans all WINDOW_MAX slots and discards each buffered packet
// synchronous active-low reset closes the connection, clears all slot valid bits at once, no sweep
`default_nettype none

module selective_repeat_receiver #(
    parameter int WINDOW_MAX  = 32,
    parameter int MAX_PAYLOAD = 1456,
    parameter int HANDLE_BITS = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    input  wire srr_pkg::t_in_word         i_item,
    output logic                           full,
    output logic                           empty,
    input  wire logic                      pop,
    output srr_pkg::t_out_word             o_result,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [srr_pkg::WIN_W-1:0] i_cfg_wr_data
);

    logic               cmd_push;
    srr_pkg::t_cmd      cmd_in;
    logic               cmd_full;
    logic               cmd_pop;
    srr_pkg::t_cmd      cmd_head;
    logic               cmd_empty;
    logic               res_push;
    srr_pkg::t_out_word res_in;
    logic               res_full;

    srr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    srr_fifo #(
        .WIDTH ($bits(srr_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    srr_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd_head),
        .i_cmd_empty   (cmd_empty),
        .o_cmd_pop     (cmd_pop),
        .o_res_push    (res_push),
        .o_res         (res_in),
        .i_res_full    (res_full)
    );

    srr_fifo #(
        .WIDTH ($bits(srr_pkg::t_out_word)),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

/* bench/srr_checker.sv */
// reply checker for the selective repeat receiver: tracks the connection and window store
// from the accepted headers, queues the replies due and compares every popped result word
// depends on srr_pkg
`default_nettype none

module srr_checker import srr_pkg::*; #(
    parameter int WINDOW_MAX  = 32,
    parameter int MAX_PAYLOAD = 1456
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic             i_full,
    input  wire t_in_word         i_item,
    input  wire logic             i_pop,
    input  wire logic             i_empty,
    input  wire t_out_word        i_result,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [WIN_W-1:0] i_cfg_wr_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic              conn_open;
    logic [SEQ_W-1:0]  next_seq;
    logic [SEQ_W-1:0]  open_seq;
    logic [FILE_W-1:0] file_idx;
    logic [WIN_W-1:0]  win_size;
    logic              slot_full [WINDOW_MAX];
    logic [HDL_W-1:0]  slot_hdl [WINDOW_MAX];
    logic [LEN_W-1:0]  slot_len [WINDOW_MAX];

    t_out_word replies_due[$];
    bit        same_header;
    int        bad_words = 0;

    task automatic drop_slots();
        for (int i = 0; i < WINDOW_MAX; i++) begin
            slot_full[i] = 1'b0;
            slot_hdl[i] = '0;
            slot_len[i] = '0;
        end
    endtask

    // the previous word of the same header loses its last flag
    task automatic queue_reply(t_kind k, logic [SEQ_W-1:0] s, logic [HDL_W-1:0] h,
                               logic [LEN_W-1:0] l);
        t_out_word w;
        t_out_word prev;
        if (same_header) begin
            prev = replies_due.pop_back();
            prev.last = 1'b0;
            replies_due.push_back(prev);
        end
        w.kind = k;
        w.out_seq = s;
        w.out_handle = h;
        w.out_length = l;
        w.file_number = file_idx;
        w.last = 1'b1;
        replies_due.push_back(w);
        same_header = 1'b1;
    endtask

    task automatic apply_header(t_in_word p);
        int unsigned      win;
        int unsigned      idx;
        logic [SEQ_W:0]   limit;
        logic [SEQ_W-1:0] s;
        same_header = 1'b0;
        if (!conn_open) begin
            if (p.action == OP_START) begin
                open_seq = p.seq_num;
                next_seq = '0;
                drop_slots();
                conn_open = 1'b1;
                queue_reply(KIND_ACK, p.seq_num, '0, '0);
            end
        end else if (p.action == OP_END) begin
            queue_reply(KIND_ACK, open_seq, '0, '0);
            for (int d = 0; d < WINDOW_MAX; d++) begin
                s = next_seq + SEQ_W'(d);
                idx = s % WINDOW_MAX;
                if (slot_full[idx]) begin
                    queue_reply(KIND_DISCARD, s, slot_hdl[idx], '0);
                    slot_full[idx] = 1'b0;
                end
            end
            conn_open = 1'b0;
            file_idx = file_idx + 1'b1;
        end else if (p.action == OP_DATA) begin
            win = (win_size < WINDOW_MAX) ? win_size : WINDOW_MAX;
            limit = {1'b0, next_seq} + (SEQ_W+1)'(win);
            if ({1'b0, p.seq_num} >= limit || p.payload_length == 0
                    || p.payload_length > MAX_PAYLOAD
                    || p.header_checksum != p.payload_crc) begin
                queue_reply(KIND_DISCARD, p.seq_num, p.payload_handle, '0);
            end else begin
                queue_reply(KIND_ACK, p.seq_num, '0, '0);
                if (p.seq_num < next_seq) begin
                    queue_reply(KIND_DISCARD, p.seq_num, p.payload_handle, '0);
                end else if (p.seq_num == next_seq) begin
                    queue_reply(KIND_DELIVER, p.seq_num, p.payload_handle, p.payload_length);
                    next_seq = next_seq + 1'b1;
                    idx = next_seq % WINDOW_MAX;
                    while (slot_full[idx]) begin
                        queue_reply(KIND_DELIVER, next_seq, slot_hdl[idx], slot_len[idx]);
                        slot_full[idx] = 1'b0;
                        next_seq = next_seq + 1'b1;
                        idx = next_seq % WINDOW_MAX;
                    end
                end else begin
                    idx = p.seq_num % WINDOW_MAX;
                    if (slot_full[idx])
                        queue_reply(KIND_DISCARD, p.seq_num, slot_hdl[idx], '0);
                    slot_full[idx] = 1'b1;
                    slot_hdl[idx] = p.payload_handle;
                    slot_len[idx] = p.payload_length;
                end
            end
        end
    endtask

    task automatic check_word(t_out_word got);
        t_out_word want;
        if (replies_due.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
                $display("srr_checker: unexpected word kind %0d seq %h hdl %h len %0d",
                         got.kind, got.out_seq, got.out_handle, got.out_length);
        end else begin
            want = replies_due.pop_front();
            if (got.kind !== want.kind || got.out_seq !== want.out_seq
                    || got.out_handle !== want.out_handle
                    || got.out_length !== want.out_length
                    || got.file_number !== want.file_number
                    || got.last !== want.last) begin
                bad_words++;
                if (bad_words <= 10)
                    $display({"srr_checker: bad word (exp/got) kind %0d/%0d seq %h/%h ",
                              "hdl %h/%h len %0d/%0d file %0d/%0d last %b/%b"},
                             want.kind, got.kind, want.out_seq, got.out_seq,
                             want.out_handle, got.out_handle, want.out_length,
                             got.out_length, want.file_number, got.file_number,
                             want.last, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            conn_open = 1'b0;
            next_seq = '0;
            open_seq = '0;
            file_idx = '0;
            win_size = WINDOW_RESET;
            drop_slots();
            replies_due.delete();
        end else begin
            if (i_cfg_wr_en)
                win_size = i_cfg_wr_data;
            if (i_pop && !i_empty)
                check_word(i_result);
            if (i_push && !i_full)
                apply_header(i_item);
        end
        o_pending <= replies_due.size();
        o_fail_count <= bad_words;
    end

endmodule

`default_nettype wire

/* bench/selective_repeat_receiver_tb.sv */
// testbench top for the selective repeat receiver: clock, reset, header stimulus in bursts,
// result pops on a stall pattern, window register phases and the final verdict
// depends on srr_pkg, srr_checker and selective_repeat_receiver
`default_nettype none

module selective_repeat_receiver_tb;
    import srr_pkg::*;

    localparam int WINDOW_MAX    = 32;
    localparam int MAX_PAYLOAD   = 1456;
    localparam int ITEMS         = 360;
    localparam int PHASES        = 7;
    localparam int SETTLE_CYCLES = 3 * WINDOW_MAX + 16;
    localparam int QUIET_LIMIT   = 2000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    t_in_word         item = '0;
    logic             full;
    logic             empty;
    logic             pop = 1'b0;
    t_out_word        result;
    logic             cfg_wr_en = 1'b0;
    logic [WIN_W-1:0] cfg_wr_data = '0;

    int fail_count;
    int pending;
    int burst_left = 0;
    int counted = 0;
    int quiet = 0;
    int stall_left = 0;
    int stall_pct = 0;
    int pattern_cnt = 0;

    selective_repeat_receiver #(
        .WINDOW_MAX(WINDOW_MAX),
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .HANDLE_BITS(HDL_W)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .i_item(item),
        .full(full),
        .empty(empty),
        .pop(pop),
        .o_result(result),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    srr_checker #(
        .WINDOW_MAX(WINDOW_MAX),
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_full(full),
        .i_item(item),
        .i_pop(pop),
        .i_empty(empty),
        .i_result(result),
        .i_cfg_wr_en(cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_in_word make_word(t_op op, logic [SEQ_W-1:0] seq,
                                           logic [LEN_W-1:0] len, bit good_sum);
        t_in_word w;
        w.action = op;
        w.seq_num = seq;
        w.payload_length = len;
        w.header_checksum = $urandom;
        w.payload_crc = good_sum ? w.header_checksum : w.header_checksum ^ ($urandom | 32'h1);
        w.payload_handle = HDL_W'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] data_len();
        case ($urandom_range(0, 7))
            0: return LEN_W'(1);
            1: return LEN_W'(MAX_PAYLOAD);
            default: return LEN_W'($urandom_range(1, MAX_PAYLOAD));
        endcase
    endfunction

    // bursts of random length, sometimes long ones with no gap at all
    task automatic send_word(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        push <= 1'b1;
        item <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        burst_left--;
        counted++;
    endtask

    // wait until every reply has come and any reply-less header has drained
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(logic [WIN_W-1:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_noise(bit in_conn);
        case ($urandom_range(0, 3))
            0: send_word(make_word(OP_BAD, $urandom, LEN_W'($urandom_range(0, 2047)),
                                   $urandom_range(0, 1)));
            1: send_word(make_word(in_conn ? OP_START : OP_END, $urandom, data_len(), 1'b1));
            2: send_word(make_word(OP_DATA, $urandom, data_len(), 1'b1));
            default: send_word(make_word(OP_DATA, $urandom_range(0, 8),
                                         LEN_W'($urandom_range(0, 2047)), 1'b1));
        endcase
    endtask

    task automatic run_directed();
        send_word(make_word(OP_DATA, '0, 11'd5, 1'b1));
        send_word(make_word(OP_END, '0, 11'd5, 1'b1));
        send_word(make_word(OP_BAD, '0, 11'd5, 1'b1));
        send_word(make_word(OP_START, '1, 11'd2047, 1'b1));
        send_word(make_word(OP_START, '0, 11'd1, 1'b1));
        send_word(make_word(OP_BAD, 32'd1, 11'd1, 1'b1));
        send_word(make_word(OP_DATA, 32'd0, LEN_W'(MAX_PAYLOAD), 1'b1));
        send_word(make_word(OP_DATA, 32'd2, 11'd1, 1'b1));
        // same slot again, old handle goes out as a discard
        send_word(make_word(OP_DATA, 32'd2, 11'd7, 1'b1));
        send_word(make_word(OP_DATA, 32'd3, 11'd1, 1'b1));
        send_word(make_word(OP_DATA, 32'd0, 11'd9, 1'b1));
        // fills the hole and drains 2 and 3
        send_word(make_word(OP_DATA, 32'd1, 11'd100, 1'b1));
        send_word(make_word(OP_DATA, 32'd4, 11'd0, 1'b1));
        send_word(make_word(OP_DATA, 32'd4, LEN_W'(MAX_PAYLOAD + 1), 1'b1));
        send_word(make_word(OP_DATA, 32'd4, 11'd2047, 1'b1));
        send_word(make_word(OP_DATA, 32'd4, 11'd10, 1'b0));
        send_word(make_word(OP_DATA, SEQ_W'(4 + WINDOW_MAX), 11'd10, 1'b1));
        send_word(make_word(OP_DATA, SEQ_W'(3 + WINDOW_MAX), 11'd10, 1'b1));
        send_word(make_word(OP_DATA, '1, 11'd10, 1'b1));
        send_word(make_word(OP_DATA, 32'd6, 11'd10, 1'b1));
        send_word(make_word(OP_END, '0, 11'd10, 1'b1));
        send_word(make_word(OP_END, '1, 11'd10, 1'b1));
    endtask

    // one connection: start, shuffled data with drops, resends and noise, end
    task automatic run_session();
        int unsigned seqs[$];
        int unsigned n;
        int unsigned k;
        int unsigned j;
        int unsigned tmp;
        int unsigned r;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(3, 14);
        for (k = 0; k < n; k++)
            seqs.push_back(k);
        for (k = 0; k + 1 < n; k++) begin
            j = k + $urandom_range(0, 5);
            if (j >= n)
                j = n - 1;
            tmp = seqs[k];
            seqs[k] = seqs[j];
            seqs[j] = tmp;
        end
        send_word(make_word(OP_START, $urandom, data_len(), 1'b1));
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r >= 6) begin
                if (r < 12)
                    send_noise(1'b1);
                send_word(make_word(OP_DATA, seqs[k], data_len(), r >= 14));
                if ($urandom_range(0, 9) == 0)
                    send_word(make_word(OP_DATA, seqs[$urandom_range(0, k)], data_len(), 1'b1));
            end
        end
        send_word(make_word(OP_END, $urandom, data_len(), 1'b1));
        if ($urandom_range(0, 3) == 0)
            send_noise(1'b0);
    endtask

    initial begin
        int target;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_window(WIN_W'(1));
                1: set_window(WIN_W'(0));
                2: set_window(WIN_W'(63));
                3: set_window(WIN_W'($urandom_range(2, 31)));
                4: set_window(WIN_W'(WINDOW_MAX));
                5: set_window(WIN_W'(2));
                default: set_window(WIN_W'($urandom_range(3, 20)));
            endcase
            target = (ph + 1) * ITEMS / PHASES;
            while (counted < target)
                run_session();
        end
        settle();
        if (fail_count == 0 && pending == 0)
            $display("selective_repeat_receiver: match");
        else
            $display("selective_repeat_receiver: mismatch");
        $finish;
    end

    // result side stalls with a mix that is picked anew after each period of random length
    always @(posedge i_clk) begin
        if (pattern_cnt == 0) begin
            pattern_cnt = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 15;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        pattern_cnt--;
        if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("selective_repeat_receiver: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule

`default_nettype wire
